/* hw/rtl/cclp_pkg.sv */
// Package of the comma separated command line parser.
// Holds the field, verdict and command codes, the keyword table and the result record.
// Used by the keyword matcher, the parser core and the top level; depends on nothing.
package cclp_pkg;

  localparam int COMMAND_CAPACITY_DEF = 32;
  localparam int NAME_CAPACITY_DEF    = 32;
  localparam int DATA_CAPACITY_DEF    = 64;

  localparam logic [7:0] CHAR_LF    = 8'h0a;
  localparam logic [7:0] CHAR_CR    = 8'h0d;
  localparam logic [7:0] CHAR_COMMA = 8'h2c;

  localparam int KW_COUNT = 8;
  localparam int KW_MAX   = 6;

  typedef enum logic [1:0] {
    FIELD_CMD  = 2'd0,
    FIELD_NAME = 2'd1,
    FIELD_DATA = 2'd2
  } field_e;

  typedef enum logic [2:0] {
    VERDICT_OK         = 3'd0,
    VERDICT_EMPTY_CMD_COMMA  = 3'd1,
    VERDICT_EMPTY_NAME_COMMA = 3'd2,
    VERDICT_FOURTH_FIELD     = 3'd3,
    VERDICT_EMPTY_CMD        = 3'd4,
    VERDICT_UNKNOWN          = 3'd5,
    VERDICT_OVERFLOW         = 3'd6
  } verdict_e;

  typedef enum logic [2:0] {
    CMD_HELP   = 3'd0,
    CMD_LIST   = 3'd1,
    CMD_FREE   = 3'd2,
    CMD_MOUNT  = 3'd3,
    CMD_PRINT  = 3'd4,
    CMD_ERASE  = 3'd5,
    CMD_CREATE = 3'd6,
    CMD_APPEND = 3'd7
  } cmd_e;

  localparam logic [7:0] KW_TEXT [KW_COUNT][KW_MAX] = '{
    '{"?", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"l", "i", "s", "t", 8'h00, 8'h00},
    '{"f", "r", "e", "e", 8'h00, 8'h00},
    '{"m", "o", "u", "n", "t", 8'h00},
    '{"p", "r", "i", "n", "t", 8'h00},
    '{"e", "r", "a", "s", "e", 8'h00},
    '{"c", "r", "e", "a", "t", "e"},
    '{"a", "p", "p", "e", "n", "d"}
  };

  localparam logic [2:0] KW_LEN [KW_COUNT] = '{
    3'd1, 3'd4, 3'd4, 3'd5, 3'd5, 3'd5, 3'd6, 3'd6
  };

  typedef struct packed {
    logic       found;
    logic [2:0] code;
  } kw_match_t;

  typedef struct packed {
    logic       payload_valid;
    logic [1:0] field_tag;
    logic [7:0] payload_byte;
    logic       line_done;
    logic [2:0] verdict;
    logic [2:0] command_code;
  } result_t;

endpackage

/* hw/rtl/cclp_keyword_matcher.sv */
// Keyword candidate register of the command line parser.
// Narrows the eight keyword candidates per command byte and looks up the command at line end.
// Depends on cclp_pkg.
module cclp_keyword_matcher import cclp_pkg::*; #(
  parameter int LenW = 5
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            step_i,
  input  logic            prune_i,
  input  logic            clear_i,
  input  logic [LenW-1:0] pos_i,
  input  logic [7:0]      byte_i,
  input  logic [LenW-1:0] len_i,
  output kw_match_t       match_o
);

  logic [KW_COUNT-1:0] cand_q, cand_d;

  always_comb begin
    cand_d = cand_q;
    if (prune_i) begin
      for (int k = 0; k < KW_COUNT; k++) begin
        if (!((7'(pos_i) < 7'(KW_LEN[k])) && (KW_TEXT[k][pos_i[2:0]] == byte_i))) begin
          cand_d[k] = 1'b0;
        end
      end
    end
  end

  // Lowest keyword index wins, as the table is searched in order.
  always_comb begin
    match_o = '0;
    for (int k = KW_COUNT - 1; k >= 0; k--) begin
      if (cand_d[k] && (7'(len_i) == 7'(KW_LEN[k]))) begin
        match_o.found = 1'b1;
        match_o.code  = 3'(k);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cand_q <= '1;
    end else if (step_i) begin
      cand_q <= clear_i ? '1 : cand_d;
    end
  end

endmodule

/* hw/rtl/cclp_parser_core.sv */
// Per-byte parsing logic: field index, field lengths, latched error and line verdict.
// Depends on cclp_pkg and cclp_keyword_matcher.
module cclp_parser_core import cclp_pkg::*; #(
  parameter int COMMAND_CAPACITY = COMMAND_CAPACITY_DEF,
  parameter int NAME_CAPACITY    = NAME_CAPACITY_DEF,
  parameter int DATA_CAPACITY    = DATA_CAPACITY_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  logic [7:0] byte_i,
  input  logic       last_i,
  output result_t    result_o
);

  localparam int CmdLenW  = $clog2(COMMAND_CAPACITY);
  localparam int NameLenW = $clog2(NAME_CAPACITY);
  localparam int DataLenW = $clog2(DATA_CAPACITY);

  field_e               field_q, field_d;
  verdict_e             err_q, err_d;
  logic [CmdLenW-1:0]   cmd_len_q, cmd_len_d;
  logic [NameLenW-1:0]  name_len_q, name_len_d;
  logic [DataLenW-1:0]  data_len_q, data_len_d;
  logic                 prune;
  kw_match_t            match;
  result_t              res_byte;

  cclp_keyword_matcher #(
    .LenW(CmdLenW)
  ) u_matcher (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (step_i),
    .prune_i (prune),
    .clear_i (last_i),
    .pos_i   (cmd_len_q),
    .byte_i  (byte_i),
    .len_i   (cmd_len_d),
    .match_o (match)
  );

  always_comb begin
    field_d    = field_q;
    err_d      = err_q;
    cmd_len_d  = cmd_len_q;
    name_len_d = name_len_q;
    data_len_d = data_len_q;
    prune      = 1'b0;
    res_byte   = '0;
    if (err_q == VERDICT_OK && byte_i != CHAR_LF && byte_i != CHAR_CR) begin
      if (byte_i == CHAR_COMMA) begin
        case (field_q)
          FIELD_CMD: begin
            if (cmd_len_q == '0) err_d = VERDICT_EMPTY_CMD_COMMA;
            else field_d = FIELD_NAME;
          end
          FIELD_NAME: begin
            if (name_len_q == '0) err_d = VERDICT_EMPTY_NAME_COMMA;
            else field_d = FIELD_DATA;
          end
          default: err_d = VERDICT_FOURTH_FIELD;
        endcase
      end else begin
        case (field_q)
          FIELD_CMD: begin
            if (cmd_len_q >= CmdLenW'(COMMAND_CAPACITY - 1)) begin
              err_d = VERDICT_OVERFLOW;
            end else begin
              prune                  = 1'b1;
              cmd_len_d              = cmd_len_q + 1'b1;
              res_byte.payload_valid = 1'b1;
              res_byte.field_tag     = FIELD_CMD;
              res_byte.payload_byte  = byte_i;
            end
          end
          FIELD_NAME: begin
            if (name_len_q >= NameLenW'(NAME_CAPACITY - 1)) begin
              err_d = VERDICT_OVERFLOW;
            end else begin
              name_len_d             = name_len_q + 1'b1;
              res_byte.payload_valid = 1'b1;
              res_byte.field_tag     = FIELD_NAME;
              res_byte.payload_byte  = byte_i;
            end
          end
          default: begin
            if (data_len_q >= DataLenW'(DATA_CAPACITY - 1)) begin
              err_d = VERDICT_OVERFLOW;
            end else begin
              data_len_d             = data_len_q + 1'b1;
              res_byte.payload_valid = 1'b1;
              res_byte.field_tag     = FIELD_DATA;
              res_byte.payload_byte  = byte_i;
            end
          end
        endcase
      end
    end
  end

  // The last byte is judged on the state it leaves behind.
  always_comb begin
    result_o = res_byte;
    if (last_i) begin
      result_o.line_done = 1'b1;
      if (err_d != VERDICT_OK) begin
        result_o.verdict = err_d;
      end else if (cmd_len_d == '0) begin
        result_o.verdict = VERDICT_EMPTY_CMD;
      end else if (!match.found) begin
        result_o.verdict = VERDICT_UNKNOWN;
      end else if ((match.code == CMD_PRINT || match.code == CMD_ERASE ||
                    match.code == CMD_CREATE) && name_len_d == '0) begin
        result_o.verdict = VERDICT_UNKNOWN;
      end else if (match.code == CMD_APPEND && (name_len_d == '0 || data_len_d == '0)) begin
        result_o.verdict = VERDICT_UNKNOWN;
      end else begin
        result_o.command_code = match.code;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      field_q    <= FIELD_CMD;
      err_q      <= VERDICT_OK;
      cmd_len_q  <= '0;
      name_len_q <= '0;
      data_len_q <= '0;
    end else if (step_i) begin
      if (last_i) begin
        field_q    <= FIELD_CMD;
        err_q      <= VERDICT_OK;
        cmd_len_q  <= '0;
        name_len_q <= '0;
        data_len_q <= '0;
      end else begin
        field_q    <= field_d;
        err_q      <= err_d;
        cmd_len_q  <= cmd_len_d;
        name_len_q <= name_len_d;
        data_len_q <= data_len_d;
      end
    end
  end

endmodule

/* hw/rtl/comma_command_line_parser_unit.sv */
// Top level of the comma separated command line parser.
// Holds the input and result registers around the parsing core.
// Depends on cclp_pkg and cclp_parser_core.
//
// Bytes of a command line enter on the slave stream, one per request, with
// tlast on the final byte of the line. Each byte gives exactly one result on
// the master stream: the payload byte tagged with its field, or nothing when
// the byte is a separator, a line break, overflows its field or comes after an
// error. The result of the final byte carries tlast, the verdict and the command code.
// A byte waits in the input register until the core steps on it, and its result
// is then written into the result register. One byte is taken per cycle while
// results are being drained; the input register and the result register
// together form a two-deep pipeline.
// When the receiver stalls, the result waits in the result register and one
// further byte waits in the input register; tready then drops until the
// result is taken.
// Reset empties both registers and returns the parser to the start of a line.
module comma_command_line_parser_unit import cclp_pkg::*; #(
  parameter int COMMAND_CAPACITY = COMMAND_CAPACITY_DEF,
  parameter int NAME_CAPACITY    = NAME_CAPACITY_DEF,
  parameter int DATA_CAPACITY    = DATA_CAPACITY_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] line_byte
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [7:0] payload_byte, [10:8] verdict, [13:11] command_code
  output logic [2:0]  m_axis_tuser,   // [0] payload_valid, [2:1] field_tag
  output logic        m_axis_tlast
);

  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       in_last_q;
  logic       out_valid_q;
  result_t    out_q;
  result_t    res;
  logic       advance;

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  cclp_parser_core #(
    .COMMAND_CAPACITY(COMMAND_CAPACITY),
    .NAME_CAPACITY   (NAME_CAPACITY),
    .DATA_CAPACITY   (DATA_CAPACITY)
  ) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .byte_i   (in_byte_q),
    .last_i   (in_last_q),
    .result_o (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready) in_valid_q <= s_axis_tvalid;
      if (advance) out_valid_q <= 1'b1;
      else if (m_axis_tready) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte_q <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
    if (advance) out_q <= res;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, out_q.command_code, out_q.verdict, out_q.payload_byte};
  assign m_axis_tuser  = {out_q.field_tag, out_q.payload_valid};
  assign m_axis_tlast  = out_q.line_done;

endmodule

/* hw/rtl/cclp_checker.sv */
// Port-level checks of the command line parser, attached to the top level by a bind.
// Depends on comma_command_line_parser_unit.
module cclp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic [2:0]  m_axis_tuser,
  input logic        m_axis_tlast
);

  // A stalled result keeps its contents.
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
      $stable(m_axis_tlast))
    else $error("result changed while stalled");

  // Only the last byte of a line carries a verdict or a command code.
  a_verdict_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tlast |-> m_axis_tdata[13:8] == 6'd0)
    else $error("verdict or command code outside line end");

  // A failed line reports no command.
  a_code_on_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[10:8] != 3'd0 |-> m_axis_tdata[13:11] == 3'd0)
    else $error("command code given with an error verdict");

  // Without a payload byte the tag and byte are zero; with one the tag names a field.
  a_payload_tag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |->
      (m_axis_tuser[0] ? m_axis_tuser[2:1] != 2'd3
                       : (m_axis_tuser[2:1] == 2'd0 && m_axis_tdata[7:0] == 8'd0)))
    else $error("payload tag inconsistent");

endmodule

bind comma_command_line_parser_unit cclp_checker u_cclp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);
